// ----- hw/rtl/sdc_pkg.sv -----
package sdc_pkg;

  typedef enum logic [2:0] {
    OP_LOCAL_REQ  = 3'd0,
    OP_REMOTE_REQ = 3'd1,
    OP_RESPONSE   = 3'd2,
    OP_CLEANUP    = 3'd3,
    OP_INVALIDATE = 3'd4,
    OP_INVAL_ACK  = 3'd5,
    OP_MARK_VALID = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_INVALID   = 3'd0,
    ST_REQUESTED = 3'd1,
    ST_VALID     = 3'd2,
    ST_INVAL_REQ = 3'd3,
    ST_CLEANUP   = 3'd4
  } st_t;

  typedef struct packed {
    logic        status;
    logic        data_valid;
    logic        must_wait;
    logic        send_request;
    logic        wake_waiters;
    logic        free_now;
    logic [63:0] sharer_mask;
    st_t         state_after;
  } sdc_result_t;

endpackage

// ----- hw/rtl/sdc_if.sv -----
interface sdc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [5:0] entry;
  logic [5:0] node;
  logic       drop_remote;
  modport source(output valid, op, entry, node, drop_remote, input ready);
  modport sink(input valid, op, entry, node, drop_remote, output ready);
endinterface

interface sdc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        data_valid;
  logic        must_wait;
  logic        send_request;
  logic        wake_waiters;
  logic        free_now;
  logic [63:0] sharer_mask;
  logic [2:0]  state_after;
  modport source(output valid, status, data_valid, must_wait, send_request, wake_waiters,
                 free_now, sharer_mask, state_after, input ready);
  modport sink(input valid, status, data_valid, must_wait, send_request, wake_waiters,
               free_now, sharer_mask, state_after, output ready);
endinterface

interface sdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] my_node;
  modport source(output valid, my_node, input ready);
  modport sink(input valid, my_node, output ready);
endinterface

// ----- hw/rtl/sdc_ram.sv -----
module sdc_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/sdc_update.sv -----
module sdc_update import sdc_pkg::*; #(
  parameter int NODES = 64
) (
  input  logic [2:0]       op,
  input  logic             entry_ok,
  input  logic [5:0]       node,
  input  logic             drop_remote,
  input  logic [5:0]       my_node,
  input  logic [NODES+3:0] cur_word,
  output logic             we,
  output logic [NODES+3:0] nxt_word,
  output sdc_result_t      res
);

  st_t              cur_st;
  logic             cur_wait;
  logic [NODES-1:0] cur_sh;
  st_t              nxt_st;
  logic             nxt_wait;
  logic [NODES-1:0] nxt_sh;
  logic             node_ok;
  logic [NODES-1:0] node_bit;
  logic             err;
  logic             dv;
  logic             wt;
  logic             sreq;
  logic             wake;
  logic             fr;
  logic [63:0]      mask;

  assign cur_st   = st_t'(cur_word[NODES+3:NODES+1]);
  assign cur_wait = cur_word[NODES];
  assign cur_sh   = cur_word[NODES-1:0];
  assign node_ok  = {1'b0, node} < 7'(NODES);
  assign node_bit = {{(NODES-1){1'b0}}, 1'b1} << node;

  always_comb begin
    nxt_st   = cur_st;
    nxt_wait = cur_wait;
    nxt_sh   = cur_sh;
    err      = 1'b0;
    dv       = 1'b0;
    wt       = 1'b0;
    sreq     = 1'b0;
    wake     = 1'b0;
    fr       = 1'b0;
    mask     = '0;
    unique case (op_t'(op))
      OP_LOCAL_REQ: begin
        if (cur_st == ST_VALID) begin
          dv = 1'b1;
        end else if (cur_st == ST_INVALID) begin
          nxt_st   = ST_REQUESTED;
          nxt_wait = 1'b1;
          wt       = 1'b1;
          sreq     = (node != my_node);
        end else if (cur_st == ST_REQUESTED) begin
          nxt_wait = 1'b1;
          wt       = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      OP_REMOTE_REQ: begin
        if (!node_ok || (cur_sh & node_bit) != '0) begin
          err = 1'b1;
        end else begin
          nxt_sh = cur_sh | node_bit;
          dv     = (cur_st == ST_VALID);
        end
      end
      OP_RESPONSE: begin
        if (cur_st == ST_REQUESTED) begin
          wake     = cur_wait;
          nxt_wait = 1'b0;
          nxt_st   = ST_VALID;
        end else begin
          err = 1'b1;
        end
      end
      OP_CLEANUP: begin
        if (cur_st != ST_VALID) begin
          err = 1'b1;
        end else if (cur_sh == '0 || drop_remote) begin
          nxt_sh = '0;
          nxt_st = ST_INVALID;
          fr     = 1'b1;
        end else begin
          nxt_st = ST_CLEANUP;
          mask   = 64'(cur_sh);
        end
      end
      OP_INVALIDATE: begin
        if (cur_st == ST_VALID) begin
          nxt_st = ST_INVALID;
        end else if (cur_st == ST_REQUESTED) begin
          nxt_st = ST_INVAL_REQ;
        end else begin
          err = 1'b1;
        end
      end
      OP_INVAL_ACK: begin
        if (!node_ok || (cur_sh & node_bit) == '0) begin
          err = 1'b1;
        end else begin
          nxt_sh = cur_sh & ~node_bit;
          if ((cur_sh & ~node_bit) == '0) begin
            nxt_st = ST_INVALID;
            fr     = 1'b1;
          end
        end
      end
      OP_MARK_VALID: begin
        mask     = 64'(cur_sh);
        nxt_st   = ST_VALID;
        wake     = cur_wait;
        nxt_wait = 1'b0;
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  assign we       = entry_ok && !err;
  assign nxt_word = {nxt_st, nxt_wait, nxt_sh};

  always_comb begin
    res = '0;
    if (!entry_ok) begin
      res.status      = 1'b1;
      res.state_after = ST_INVALID;
    end else begin
      res.status       = err;
      res.data_valid   = dv;
      res.must_wait    = wt;
      res.send_request = sreq;
      res.wake_waiters = wake;
      res.free_now     = fr;
      res.sharer_mask  = mask;
      res.state_after  = err ? cur_st : nxt_st;
    end
  end

endmodule

// ----- hw/rtl/sharer_directory_coherence.sv -----
// Channel   Direction  Beat contents
// in_ch     sink       op, entry, node, drop_remote
// out_ch    source     status, data_valid, must_wait, send_request, wake_waiters,
//                      free_now, sharer_mask, state_after
// cfg_ch    sink       my_node
//
// One beat per cycle is sustained unless the output stalls; a result is offered from
// the output register once its beat has left the update stage. The single directory
// memory is read when a beat is accepted and written back from the update stage, with
// the last write forwarded to the following beat. After reset a clearing pass writes
// every entry, accepting no input beat; configuration writes are taken throughout.
// A stalled output holds the pending beat in the update stage and stops input.
module sharer_directory_coherence import sdc_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int NODES   = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  sdc_in_if.sink    in_ch,
  sdc_out_if.source out_ch,
  sdc_cfg_if.sink   cfg_ch
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = NODES + 4;

  logic [5:0]    my_node_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  logic          s1_vld_r;
  logic [2:0]    s1_op_r;
  logic          s1_entry_ok_r;
  logic [AW-1:0] s1_addr_r;
  logic [5:0]    s1_node_r;
  logic          s1_drop_r;

  logic          wr_vld_r;
  logic [AW-1:0] wr_addr_r;
  logic [WW-1:0] wr_data_r;

  logic          out_vld_r;
  sdc_result_t   out_res_r;

  logic          s1_go;
  logic          in_acc;
  logic [12:0]   in_ent_ext;
  logic          in_entry_ok;
  logic [AW-1:0] in_addr;
  logic [WW-1:0] ram_rdata;
  logic [WW-1:0] cur_word;
  logic          upd_we;
  logic [WW-1:0] upd_word;
  sdc_result_t   upd_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;

  assign cfg_ch.ready = 1'b1;
  assign s1_go        = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !clr_active_r && (!s1_vld_r || s1_go);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ent_ext   = 13'(in_ch.entry);
  assign in_entry_ok  = in_ent_ext < 13'(ENTRIES);
  assign in_addr      = in_ent_ext[AW-1:0];

  assign cur_word  = (wr_vld_r && wr_addr_r == s1_addr_r) ? wr_data_r : ram_rdata;
  assign ram_we    = clr_active_r || (s1_vld_r && s1_go && upd_we);
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_active_r ? '0 : upd_word;

  sdc_ram #(
    .WIDTH(WW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_acc),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  sdc_update #(
    .NODES(NODES)
  ) u_update (
    .op         (s1_op_r),
    .entry_ok   (s1_entry_ok_r),
    .node       (s1_node_r),
    .drop_remote(s1_drop_r),
    .my_node    (my_node_r),
    .cur_word   (cur_word),
    .we         (upd_we),
    .nxt_word   (upd_word),
    .res        (upd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_node_r    <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_vld_r     <= 1'b0;
      wr_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        my_node_r <= cfg_ch.my_node;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(ENTRIES - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (ram_we) begin
        wr_vld_r <= 1'b1;
      end
      if (s1_vld_r && s1_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r       <= in_ch.op;
      s1_entry_ok_r <= in_entry_ok;
      s1_addr_r     <= in_addr;
      s1_node_r     <= in_ch.node;
      s1_drop_r     <= in_ch.drop_remote;
    end
    if (ram_we) begin
      wr_addr_r <= ram_waddr;
      wr_data_r <= ram_wdata;
    end
    if (s1_vld_r && s1_go) begin
      out_res_r <= upd_res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.data_valid   = out_res_r.data_valid;
  assign out_ch.must_wait    = out_res_r.must_wait;
  assign out_ch.send_request = out_res_r.send_request;
  assign out_ch.wake_waiters = out_res_r.wake_waiters;
  assign out_ch.free_now     = out_res_r.free_now;
  assign out_ch.sharer_mask  = out_res_r.sharer_mask;
  assign out_ch.state_after  = out_res_r.state_after;

  a_accept_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted beat did not reach the update stage");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!s1_vld_r && !in_ch.ready))
    else $error("beat in flight during the clearing pass");

  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && upd_res.status) |-> !upd_we)
    else $error("protocol error would modify the entry");

  a_stage_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_go) |=> (s1_vld_r && $stable(s1_addr_r) && $stable(s1_op_r)))
    else $error("update stage lost its beat while the output was stalled");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb import sdc_pkg::*; ();

  localparam logic [2:0] OP_RESERVED = 3'd7;

  logic clk;
  logic rst_n;

  sdc_in_if  in_ch();
  sdc_out_if out_ch();
  sdc_cfg_if cfg_ch();

  sharer_directory_coherence #(
    .ENTRIES(64),
    .NODES(64)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  st_t         dir_state [64];
  logic        waiter    [64];
  logic [63:0] sharers   [64];
  logic [5:0]  my_node_cfg;

  sdc_result_t expected_results[$];

  int  errors;
  int  items_sent;
  int  results_checked;
  int  burst_left;
  int  hold_req;
  int  hold_left;
  int  stall_left;
  bit  gaps_on;
  bit  stalls_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic sdc_result_t directory_update(input logic [2:0] op, input logic [5:0] e,
                                                   input logic [5:0] nd, input logic lo);
    sdc_result_t r;
    logic [63:0] node_bit;
    st_t         st;
    r = '0;
    st = dir_state[e];
    node_bit = 64'd1 << nd;
    case (op)
      OP_LOCAL_REQ: begin
        if (st == ST_VALID) begin
          r.data_valid = 1'b1;
        end else if (st == ST_INVALID) begin
          dir_state[e] = ST_REQUESTED;
          waiter[e] = 1'b1;
          r.must_wait = 1'b1;
          r.send_request = (nd != my_node_cfg);
        end else if (st == ST_REQUESTED) begin
          waiter[e] = 1'b1;
          r.must_wait = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_REMOTE_REQ: begin
        if ((sharers[e] & node_bit) != 64'd0) begin
          r.status = 1'b1;
        end else begin
          sharers[e] = sharers[e] | node_bit;
          r.data_valid = (st == ST_VALID);
        end
      end
      OP_RESPONSE: begin
        if (st == ST_REQUESTED) begin
          r.wake_waiters = waiter[e];
          waiter[e] = 1'b0;
          dir_state[e] = ST_VALID;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_CLEANUP: begin
        if (st != ST_VALID) begin
          r.status = 1'b1;
        end else if (sharers[e] == 64'd0 || lo) begin
          sharers[e] = 64'd0;
          dir_state[e] = ST_INVALID;
          r.free_now = 1'b1;
        end else begin
          dir_state[e] = ST_CLEANUP;
          r.sharer_mask = sharers[e];
        end
      end
      OP_INVALIDATE: begin
        if (st == ST_VALID) begin
          dir_state[e] = ST_INVALID;
        end else if (st == ST_REQUESTED) begin
          dir_state[e] = ST_INVAL_REQ;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_INVAL_ACK: begin
        if ((sharers[e] & node_bit) == 64'd0) begin
          r.status = 1'b1;
        end else begin
          sharers[e] = sharers[e] & ~node_bit;
          if (sharers[e] == 64'd0) begin
            dir_state[e] = ST_INVALID;
            r.free_now = 1'b1;
          end
        end
      end
      OP_MARK_VALID: begin
        r.sharer_mask = sharers[e];
        dir_state[e] = ST_VALID;
        r.wake_waiters = waiter[e];
        waiter[e] = 1'b0;
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.state_after = dir_state[e];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    sdc_result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with no prediction waiting", $time);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("data_valid", 64'(want.data_valid), 64'(out_ch.data_valid));
        check_field("must_wait", 64'(want.must_wait), 64'(out_ch.must_wait));
        check_field("send_request", 64'(want.send_request), 64'(out_ch.send_request));
        check_field("wake_waiters", 64'(want.wake_waiters), 64'(out_ch.wake_waiters));
        check_field("free_now", 64'(want.free_now), 64'(out_ch.free_now));
        check_field("sharer_mask", want.sharer_mask, out_ch.sharer_mask);
        check_field("state_after", 64'(want.state_after), 64'(out_ch.state_after));
        results_checked++;
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!stalls_on) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  task automatic in_idle(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [5:0] e, input logic [5:0] nd,
                           input logic lo);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_idle($urandom_range(1, 5));
      end
      burst_left--;
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.entry       <= e;
    in_ch.node        <= nd;
    in_ch.drop_remote <= lo;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results.push_back(directory_update(op, e, nd, lo));
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_my_node(input logic [5:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.my_node <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    my_node_cfg = v;
  endtask

  function automatic logic [5:0] pick_sharer(input logic [5:0] e);
    logic [5:0] n;
    n = 6'($urandom);
    for (int i = 0; i < 64; i++) begin
      if (sharers[e][n]) return n;
      n = n + 6'd1;
    end
    return n;
  endfunction

  function automatic logic [5:0] pick_stranger(input logic [5:0] e);
    logic [5:0] n;
    n = 6'($urandom);
    for (int i = 0; i < 64; i++) begin
      if (!sharers[e][n]) return n;
      n = n + 6'd1;
    end
    return n;
  endfunction

  task automatic send_coherent(input logic [5:0] e);
    logic [2:0] op;
    logic [5:0] nd;
    logic       lo;
    int         r;
    op = 3'($urandom);
    nd = 6'($urandom);
    lo = 1'($urandom);
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 99) >= 12) begin
      case (dir_state[e])
        ST_INVALID: begin
          if (r < 5) begin
            op = OP_LOCAL_REQ;
            if (r == 0) nd = my_node_cfg;
          end else if (r < 8) begin
            op = OP_REMOTE_REQ;
            nd = pick_stranger(e);
          end else if (r < 9 || sharers[e] == 64'd0) begin
            op = OP_MARK_VALID;
          end else begin
            op = OP_INVAL_ACK;
            nd = pick_sharer(e);
          end
        end
        ST_REQUESTED: begin
          if (r < 2) begin
            op = OP_LOCAL_REQ;
          end else if (r < 5) begin
            op = OP_RESPONSE;
          end else if (r < 6) begin
            op = OP_INVALIDATE;
          end else if (r < 8) begin
            op = OP_REMOTE_REQ;
            nd = pick_stranger(e);
          end else if (r < 9) begin
            op = OP_MARK_VALID;
          end else begin
            op = OP_INVAL_ACK;
            nd = pick_sharer(e);
          end
        end
        ST_VALID: begin
          if (r < 2) begin
            op = OP_LOCAL_REQ;
          end else if (r < 5) begin
            op = OP_REMOTE_REQ;
            nd = pick_stranger(e);
          end else if (r < 7) begin
            op = OP_CLEANUP;
          end else if (r < 8) begin
            op = OP_INVALIDATE;
          end else if (r < 9) begin
            op = OP_INVAL_ACK;
            nd = pick_sharer(e);
          end else begin
            op = OP_MARK_VALID;
          end
        end
        ST_INVAL_REQ: begin
          if (r < 5) begin
            op = OP_MARK_VALID;
          end else if (r < 7) begin
            op = OP_REMOTE_REQ;
            nd = pick_stranger(e);
          end else begin
            op = OP_INVAL_ACK;
            nd = pick_sharer(e);
          end
        end
        default: begin
          if (r < 8) begin
            op = OP_INVAL_ACK;
            nd = pick_sharer(e);
          end else if (r < 9) begin
            op = OP_REMOTE_REQ;
            nd = pick_stranger(e);
          end else begin
            op = OP_MARK_VALID;
          end
        end
      endcase
    end
    send_item(op, e, nd, lo);
  endtask

  task automatic test_local_request_flow();
    send_item(OP_LOCAL_REQ, 6'd0, 6'd0, 1'b0);
    send_item(OP_LOCAL_REQ, 6'd0, 6'd17, 1'b0);
    send_item(OP_RESPONSE, 6'd0, 6'd0, 1'b0);
    send_item(OP_LOCAL_REQ, 6'd0, 6'd42, 1'b0);
    send_item(OP_LOCAL_REQ, 6'd63, 6'd63, 1'b0);
  endtask

  task automatic test_sharer_tracking();
    send_item(OP_REMOTE_REQ, 6'd0, 6'd63, 1'b0);
    send_item(OP_REMOTE_REQ, 6'd0, 6'd63, 1'b0);
    send_item(OP_INVAL_ACK, 6'd0, 6'd5, 1'b0);
    send_item(OP_REMOTE_REQ, 6'd63, 6'd0, 1'b1);
  endtask

  task automatic test_cleanup_paths();
    send_item(OP_CLEANUP, 6'd0, 6'd0, 1'b0);
    send_item(OP_LOCAL_REQ, 6'd0, 6'd1, 1'b0);
    send_item(OP_INVAL_ACK, 6'd0, 6'd63, 1'b0);
    send_item(OP_MARK_VALID, 6'd10, 6'd0, 1'b0);
    send_item(OP_CLEANUP, 6'd10, 6'd0, 1'b0);
  endtask

  task automatic test_invalidate_and_mark_valid();
    send_item(OP_INVALIDATE, 6'd63, 6'd0, 1'b0);
    send_item(OP_LOCAL_REQ, 6'd63, 6'd0, 1'b0);
    send_item(OP_MARK_VALID, 6'd63, 6'd0, 1'b0);
    send_item(OP_INVALIDATE, 6'd63, 6'd0, 1'b0);
    send_item(OP_MARK_VALID, 6'd63, 6'd0, 1'b0);
    send_item(OP_CLEANUP, 6'd63, 6'd0, 1'b1);
  endtask

  task automatic test_protocol_errors();
    send_item(OP_RESPONSE, 6'd0, 6'd0, 1'b0);
    send_item(OP_CLEANUP, 6'd0, 6'd0, 1'b0);
    send_item(OP_INVALIDATE, 6'd0, 6'd0, 1'b0);
    send_item(OP_RESERVED, 6'd5, 6'd63, 1'b1);
  endtask

  task automatic test_full_sharer_set();
    logic [5:0] e;
    e = 6'd33;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    if (dir_state[e] == ST_INVALID) send_item(OP_LOCAL_REQ, e, 6'd12, 1'b0);
    send_item(OP_MARK_VALID, e, 6'd0, 1'b0);
    for (int n = 0; n < 64; n++) send_item(OP_REMOTE_REQ, e, n[5:0], 1'b0);
    send_item(OP_CLEANUP, e, 6'd0, 1'b0);
    for (int n = 63; n >= 0; n--) send_item(OP_INVAL_ACK, e, n[5:0], 1'b0);
  endtask

  task automatic test_random_traffic(input int n, input bit gaps, input bit stalls);
    logic [5:0] pool [6];
    logic [5:0] e;
    gaps_on = gaps;
    stalls_on = stalls;
    foreach (pool[i]) pool[i] = 6'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) e = 6'($urandom);
      else e = pool[$urandom_range(0, 5)];
      send_coherent(e);
    end
  endtask

  task automatic test_output_backpressure();
    logic [5:0] e;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    e = 6'($urandom);
    hold_req = 200;
    for (int i = 0; i < 60; i++) send_coherent(($urandom_range(0, 1) == 0) ? e : e + 6'd1);
    stalls_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      dir_state[i] = ST_INVALID;
      waiter[i] = 1'b0;
      sharers[i] = 64'd0;
    end
    my_node_cfg = 6'd0;
    errors = 0;
    items_sent = 0;
    results_checked = 0;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    stall_left = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= '0;
    in_ch.entry       <= '0;
    in_ch.node        <= '0;
    in_ch.drop_remote <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.my_node    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_my_node(6'd0);
    test_local_request_flow();
    test_sharer_tracking();
    test_invalidate_and_mark_valid();
    test_cleanup_paths();
    test_protocol_errors();

    write_my_node(6'd63);
    test_full_sharer_set();
    test_random_traffic(320, 1'b0, 1'b0);
    write_my_node(6'd0);
    test_random_traffic(320, 1'b1, 1'b1);
    write_my_node(6'($urandom_range(1, 62)));
    test_random_traffic(320, 1'b1, 1'b1);
    write_my_node(6'($urandom_range(1, 62)));
    test_random_traffic(320, 1'b0, 1'b1);
    write_my_node(6'd63);
    test_random_traffic(320, 1'b1, 1'b0);
    test_output_backpressure();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Run covered %0d operations: directed protocol cases, a full sharer set,",
             items_sent);
    $display("random traffic under several node ids and a long output stall; %0d beats checked.",
             results_checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sdc_pkg.sv
hw/rtl/sdc_if.sv
hw/rtl/sdc_ram.sv
hw/rtl/sdc_update.sv
hw/rtl/sharer_directory_coherence.sv
bench/tb.sv
